// ===== hw/rtl/irfd_pkg.sv =====
// Shared types and constants for the infrared remote frame decoder.
`timescale 1ns / 1ps
`default_nettype none

package irfd_pkg;

  localparam int unsigned FrameBitsDef = 112;
  localparam int unsigned NumBytes     = 14;
  localparam int unsigned IntervalW    = 16;
  localparam int unsigned CfgIdxW      = 2;

  localparam logic [IntervalW-1:0] BitLowLimitRst  = 16'd800;
  localparam logic [IntervalW-1:0] BitHighLimitRst = 16'd2300;
  localparam logic [IntervalW-1:0] OneThresholdRst = 16'd2100;

  localparam logic [CfgIdxW-1:0] CfgBitLowLimit  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgBitHighLimit = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgOneThreshold = 2'd2;

  localparam logic [7:0] CmdPower      = 8'h85;
  localparam logic [7:0] CmdTempA      = 8'h80;
  localparam logic [7:0] CmdTempB      = 8'h81;
  localparam logic [7:0] CmdMode       = 8'h86;
  localparam logic [7:0] CmdFan        = 8'h84;
  localparam logic [7:0] CmdResvToggle = 8'h8B;
  localparam logic [7:0] CmdResvSelect = 8'h82;

  localparam logic [7:0] Pat40 = 8'h40;
  localparam logic [7:0] PatC0 = 8'hC0;
  localparam logic [7:0] Pat80 = 8'h80;
  localparam logic [7:0] Pat20 = 8'h20;

  localparam logic [7:0] TempSetSel  = 8'h00;
  localparam logic [7:0] TempResvSel = 8'h02;

  localparam logic [7:0] FanCode0 = 8'h60;
  localparam logic [7:0] FanCode1 = 8'h40;
  localparam logic [7:0] FanCode2 = 8'h20;
  localparam logic [7:0] FanCode3 = 8'hA0;

  localparam logic [4:0] TempRst = 5'd16;

  typedef logic [NumBytes-1:0][7:0] frame_bytes_t;

  typedef struct packed {
    logic [IntervalW-1:0] low_limit;
    logic [IntervalW-1:0] high_limit;
    logic [IntervalW-1:0] one_thr;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic value;
  } bit_t;

  typedef struct packed {
    logic       power;
    logic [4:0] temp;
    logic [4:0] resv_time;
    logic [4:0] resv_temp;
    logic [1:0] mode;
    logic [1:0] speed;
    logic       resv_on;
    logic       resv_sel;
  } settings_t;

endpackage

`default_nettype wire

// ===== hw/rtl/irfd_bit_slicer.sv =====
// Interval classifier: decides whether an interval is a data bit and its value.
`timescale 1ns / 1ps
`default_nettype none

module irfd_bit_slicer
  import irfd_pkg::*;
(
  input  logic [IntervalW-1:0] interval_i,
  input  cfg_t                 cfg_i,
  output bit_t                 bit_o
);

  assign bit_o.valid = (interval_i > cfg_i.low_limit) && (interval_i < cfg_i.high_limit);
  assign bit_o.value = interval_i > cfg_i.one_thr;

endmodule

`default_nettype wire

// ===== hw/rtl/irfd_frame_store.sv =====
// Bit counter and frame byte store, with the merged byte view for decode.
`timescale 1ns / 1ps
`default_nettype none

module irfd_frame_store
  import irfd_pkg::*;
#(
  parameter int unsigned FrameBits = FrameBitsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         step_i,
  input  bit_t         bit_i,
  output logic         done_o,
  output frame_bytes_t bytes_o
);

  localparam int unsigned CntW  = $clog2(FrameBits);
  localparam int unsigned ByteW = CntW - 3;

  logic [CntW-1:0]  count_q, count_d;
  frame_bytes_t     bytes_q, bytes_d;
  logic [ByteW-1:0] byte_idx;
  logic [2:0]       bit_pos;

  assign byte_idx = count_q[CntW-1:3];
  assign bit_pos  = ~count_q[2:0];
  assign done_o   = bit_i.valid && (count_q == CntW'(FrameBits - 1));

  always_comb begin
    bytes_d = bytes_q;
    for (int b = 0; b < NumBytes; b++) begin
      if (bit_i.valid && (byte_idx == ByteW'(b))) begin
        bytes_d[b][bit_pos] = bit_i.value;
      end
    end
  end

  always_comb begin
    if (!bit_i.valid || done_o) begin
      count_d = '0;
    end else begin
      count_d = count_q + 1'b1;
    end
  end

  assign bytes_o = bytes_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (step_i) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      bytes_q <= bytes_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/irfd_cmd_decoder.sv =====
// Command decoder: applies a completed frame to the current settings.
`timescale 1ns / 1ps
`default_nettype none

module irfd_cmd_decoder
  import irfd_pkg::*;
(
  input  logic         done_i,
  input  frame_bytes_t bytes_i,
  input  settings_t    cur_i,
  output settings_t    next_o,
  output logic         error_o
);

  logic [7:0] cmd, b3, b4, b5, b7;
  logic [4:0] tval;
  logic       pat_a, pat_b, pat_c;

  assign cmd  = bytes_i[12];
  assign b3   = bytes_i[3];
  assign b4   = bytes_i[4];
  assign b5   = bytes_i[5];
  assign b7   = bytes_i[7];
  assign tval = {1'b1, bytes_i[1][7:4]};

  assign pat_a = (b4 == Pat40) && (b7 == Pat20);
  assign pat_b = (b4 == PatC0) && (b7 == Pat80);
  assign pat_c = (b4 == Pat40) && (b7 == Pat40);

  always_comb begin
    next_o  = cur_i;
    error_o = 1'b0;
    if (done_i) begin
      if (cmd == CmdPower) begin
        next_o.power = pat_a || pat_b || pat_c;
      end else if (cmd inside {CmdTempA, CmdTempB}) begin
        if (b3 == TempSetSel) begin
          next_o.temp = tval;
        end else if (b3 == TempResvSel) begin
          if (!cur_i.resv_sel) begin
            next_o.resv_time = tval;
          end else begin
            next_o.resv_temp = tval;
          end
        end else begin
          error_o = 1'b1;
        end
      end else if (cmd == CmdMode) begin
        if (pat_c) begin
          next_o.mode = 2'd0;
        end else if (pat_b) begin
          next_o.mode = 2'd1;
        end else if (pat_a) begin
          next_o.mode = 2'd2;
        end
      end else if (cmd == CmdFan) begin
        case (b5)
          FanCode0: next_o.speed = 2'd0;
          FanCode1: next_o.speed = 2'd1;
          FanCode2: next_o.speed = 2'd2;
          FanCode3: next_o.speed = 2'd3;
          default:  next_o.speed = cur_i.speed;
        endcase
      end else if (cmd == CmdResvToggle) begin
        next_o.resv_on = ~cur_i.resv_on;
      end else if (cmd == CmdResvSelect) begin
        next_o.resv_sel = ~cur_i.resv_sel;
      end else begin
        error_o = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ir_remote_frame_decoder_core.sv =====
// Top level of the infrared remote frame decoder.
// Takes one edge interval per request and returns one result per request
// holding the unit settings after that interval. Throughput is one request
// per clock while results are taken; each request passes the input register,
// the bit and command update and then the result register. While a result
// waits, the input register still takes one request. The user must write limits
// through the configuration channel only while the block is idle; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module ir_remote_frame_decoder_core
  import irfd_pkg::*;
#(
  parameter int unsigned FrameBits = FrameBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,

  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [IntervalW-1:0] cfg_data_i,

  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [IntervalW-1:0] pulse_interval_i,

  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 power_on_o,
  output logic [4:0]           set_temperature_o,
  output logic [4:0]           reserve_time_value_o,
  output logic [4:0]           reserve_temperature_o,
  output logic [1:0]           op_mode_o,
  output logic [1:0]           fan_speed_o,
  output logic                 reserve_enabled_o,
  output logic                 reserve_field_select_o,
  output logic                 frame_done_o,
  output logic                 frame_error_o
);

  cfg_t                 cfg_q;
  logic                 in_valid_q;
  logic [IntervalW-1:0] interval_q;
  logic                 out_valid_q;
  settings_t            set_q, set_d;
  settings_t            res_set_q;
  logic                 res_done_q, res_err_q;

  logic                 step;
  bit_t                 bit_s;
  logic                 done;
  logic                 err;
  frame_bytes_t         bytes;

  assign cfg_ready_o = 1'b1;
  assign step        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_limit  <= BitLowLimitRst;
      cfg_q.high_limit <= BitHighLimitRst;
      cfg_q.one_thr    <= OneThresholdRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgBitLowLimit:  cfg_q.low_limit  <= cfg_data_i;
        CfgBitHighLimit: cfg_q.high_limit <= cfg_data_i;
        CfgOneThreshold: cfg_q.one_thr    <= cfg_data_i;
        default:         cfg_q            <= cfg_q;
      endcase
    end
  end

  // hold the request until the update stage takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      interval_q <= pulse_interval_i;
    end
  end

  irfd_bit_slicer u_slicer (
    .interval_i (interval_q),
    .cfg_i      (cfg_q),
    .bit_o      (bit_s)
  );

  irfd_frame_store #(
    .FrameBits (FrameBits)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .bit_i   (bit_s),
    .done_o  (done),
    .bytes_o (bytes)
  );

  irfd_cmd_decoder u_decoder (
    .done_i  (done),
    .bytes_i (bytes),
    .cur_i   (set_q),
    .next_o  (set_d),
    .error_o (err)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_q.power     <= 1'b1;
      set_q.temp      <= TempRst;
      set_q.resv_time <= TempRst;
      set_q.resv_temp <= TempRst;
      set_q.mode      <= 2'd0;
      set_q.speed     <= 2'd0;
      set_q.resv_on   <= 1'b0;
      set_q.resv_sel  <= 1'b0;
    end else if (step) begin
      set_q <= set_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_set_q  <= set_d;
      res_done_q <= done;
      res_err_q  <= err;
    end
  end

  assign out_valid_o            = out_valid_q;
  assign power_on_o             = res_set_q.power;
  assign set_temperature_o      = res_set_q.temp;
  assign reserve_time_value_o   = res_set_q.resv_time;
  assign reserve_temperature_o  = res_set_q.resv_temp;
  assign op_mode_o              = res_set_q.mode;
  assign fan_speed_o            = res_set_q.speed;
  assign reserve_enabled_o      = res_set_q.resv_on;
  assign reserve_field_select_o = res_set_q.resv_sel;
  assign frame_done_o           = res_done_q;
  assign frame_error_o          = res_err_q;

endmodule

`default_nettype wire

// ===== tb/sv/tb_ir_remote_frame_decoder_core.sv =====
// Self-checking testbench for the infrared remote frame decoder core.
`timescale 1ns / 1ps

module tb_ir_remote_frame_decoder_core;
  import irfd_pkg::*;

  localparam int unsigned FrameBits  = FrameBitsDef;
  localparam int unsigned CycleLimit = 1_200_000;

  localparam logic [7:0] CmdUnknown = 8'h00;
  localparam logic [7:0] TempBadSel = 8'h05;
  localparam logic [7:0] PatNone    = 8'h00;

  typedef struct packed {
    settings_t st;
    logic      done;
    logic      err;
  } report_t;

  typedef enum logic { RowPulse, RowFrame } row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [IntervalW-1:0] interval;
    frame_bytes_t         bytes;
    logic                 typed;
    report_t              want;
  } stim_row_t;

  localparam settings_t SettingsRst = '{power: 1'b1, temp: TempRst, resv_time: TempRst,
                                        resv_temp: TempRst, mode: 2'd0, speed: 2'd0,
                                        resv_on: 1'b0, resv_sel: 1'b0};
  localparam report_t ReportIdle   = '{st: SettingsRst, done: 1'b0, err: 1'b0};
  localparam report_t ReportBadCmd = '{st: SettingsRst, done: 1'b1, err: 1'b1};

  logic                 clk;
  logic                 rst_n          = 1'b0;
  logic                 cfg_valid      = 1'b0;
  logic                 cfg_ready;
  logic [CfgIdxW-1:0]   cfg_index      = CfgBitLowLimit;
  logic [IntervalW-1:0] cfg_data       = '0;
  logic                 in_valid       = 1'b0;
  logic                 in_ready;
  logic [IntervalW-1:0] pulse_interval = '0;
  logic                 out_valid;
  logic                 out_ready      = 1'b0;
  logic                 power_on;
  logic [4:0]           set_temperature;
  logic [4:0]           reserve_time_value;
  logic [4:0]           reserve_temperature;
  logic [1:0]           op_mode;
  logic [1:0]           fan_speed;
  logic                 reserve_enabled;
  logic                 reserve_field_select;
  logic                 frame_done;
  logic                 frame_error;

  logic [IntervalW-1:0] lim_low;
  logic [IntervalW-1:0] lim_high;
  logic [IntervalW-1:0] thr_one;
  logic [6:0]           bit_cnt;
  frame_bytes_t         frame_store;
  settings_t            unit_state;
  report_t              due_reports[$];
  stim_row_t            dir_rows[$];
  int unsigned          mismatch_cnt = 0;
  int unsigned          sent_cnt     = 0;
  int unsigned          cycle_cnt    = 0;
  bit                   no_gaps      = 1'b0;

  ir_remote_frame_decoder_core uut (
    .clk_i                  (clk),
    .rst_ni                 (rst_n),
    .cfg_valid_i            (cfg_valid),
    .cfg_ready_o            (cfg_ready),
    .cfg_index_i            (cfg_index),
    .cfg_data_i             (cfg_data),
    .in_valid_i             (in_valid),
    .in_ready_o             (in_ready),
    .pulse_interval_i       (pulse_interval),
    .out_valid_o            (out_valid),
    .out_ready_i            (out_ready),
    .power_on_o             (power_on),
    .set_temperature_o      (set_temperature),
    .reserve_time_value_o   (reserve_time_value),
    .reserve_temperature_o  (reserve_temperature),
    .op_mode_o              (op_mode),
    .fan_speed_o            (fan_speed),
    .reserve_enabled_o      (reserve_enabled),
    .reserve_field_select_o (reserve_field_select),
    .frame_done_o           (frame_done),
    .frame_error_o          (frame_error)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic apply_frame_command();
    logic [7:0] cmd;
    logic [7:0] b4;
    logic [7:0] b7;
    logic [4:0] tval;
    cmd  = frame_store[12];
    b4   = frame_store[4];
    b7   = frame_store[7];
    tval = TempRst + {1'b0, frame_store[1][7:4]};
    case (cmd)
      CmdPower: begin
        unit_state.power = (b4 == Pat40 && b7 == Pat20) || (b4 == PatC0 && b7 == Pat80) ||
                           (b4 == Pat40 && b7 == Pat40);
      end
      CmdTempA, CmdTempB: begin
        if (frame_store[3] == TempSetSel) begin
          unit_state.temp = tval;
        end else if (frame_store[3] == TempResvSel) begin
          if (unit_state.resv_sel) begin
            unit_state.resv_temp = tval;
          end else begin
            unit_state.resv_time = tval;
          end
        end else begin
          return 1'b1;
        end
      end
      CmdMode: begin
        if (b4 == Pat40 && b7 == Pat40) begin
          unit_state.mode = 2'd0;
        end else if (b4 == PatC0 && b7 == Pat80) begin
          unit_state.mode = 2'd1;
        end else if (b4 == Pat40 && b7 == Pat20) begin
          unit_state.mode = 2'd2;
        end
      end
      CmdFan: begin
        case (frame_store[5])
          FanCode0: unit_state.speed = 2'd0;
          FanCode1: unit_state.speed = 2'd1;
          FanCode2: unit_state.speed = 2'd2;
          FanCode3: unit_state.speed = 2'd3;
          default: ;
        endcase
      end
      CmdResvToggle: unit_state.resv_on = ~unit_state.resv_on;
      CmdResvSelect: unit_state.resv_sel = ~unit_state.resv_sel;
      default: return 1'b1;
    endcase
    return 1'b0;
  endfunction

  function automatic report_t decode_interval(input logic [IntervalW-1:0] iv);
    report_t     r;
    int unsigned k;
    r = ReportIdle;
    if (iv > lim_low && iv < lim_high) begin
      k = {25'd0, bit_cnt};
      if (k < 8 * NumBytes) frame_store[k / 8][7 - k % 8] = (iv > thr_one);
      if (k >= FrameBits - 1) begin
        r.done  = 1'b1;
        r.err   = apply_frame_command();
        bit_cnt = '0;
      end else begin
        bit_cnt = bit_cnt + 7'd1;
      end
    end else begin
      bit_cnt = '0;
    end
    r.st = unit_state;
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [IntervalW-1:0] out_interval();
    if ($urandom_range(0, 1)) return 16'($urandom_range(int'(lim_low), 0));
    return 16'($urandom_range(32'hFFFF, int'(lim_high)));
  endfunction

  function automatic logic [IntervalW-1:0] bit_interval(input logic b);
    int lo;
    int hi;
    lo = int'(lim_low) + 1;
    hi = int'(lim_high) - 1;
    if (lo > hi) return out_interval();
    if (b && int'(thr_one) + 1 <= hi) begin
      if (int'(thr_one) + 1 > lo) lo = int'(thr_one) + 1;
    end else if (!b && int'(thr_one) >= lo) begin
      if (int'(thr_one) < hi) hi = int'(thr_one);
    end
    case ($urandom_range(0, 9))
      0: return 16'(lo);
      1: return 16'(hi);
      default: return 16'($urandom_range(hi, lo));
    endcase
  endfunction

  function automatic frame_bytes_t cmd_frame(input logic [7:0] cmd, b1, b3, b4, b5, b7);
    frame_bytes_t f;
    for (int i = 0; i < NumBytes; i++) f[i] = 8'($urandom);
    f[1]  = b1;
    f[3]  = b3;
    f[4]  = b4;
    f[5]  = b5;
    f[7]  = b7;
    f[12] = cmd;
    return f;
  endfunction

  function automatic frame_bytes_t random_frame();
    logic [7:0] cmd;
    logic [7:0] b3;
    logic [7:0] b4;
    logic [7:0] b5;
    logic [7:0] b7;
    case ($urandom_range(0, 8))
      0: cmd = CmdPower;
      1: cmd = CmdTempA;
      2: cmd = CmdTempB;
      3: cmd = CmdMode;
      4: cmd = CmdFan;
      5: cmd = CmdResvToggle;
      6: cmd = CmdResvSelect;
      default: cmd = 8'($urandom);
    endcase
    case ($urandom_range(0, 4))
      0, 1: b3 = TempSetSel;
      2, 3: b3 = TempResvSel;
      default: b3 = 8'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0: {b4, b7} = {Pat40, Pat20};
      1: {b4, b7} = {PatC0, Pat80};
      2: {b4, b7} = {Pat40, Pat40};
      default: {b4, b7} = 16'($urandom);
    endcase
    case ($urandom_range(0, 4))
      0: b5 = FanCode0;
      1: b5 = FanCode1;
      2: b5 = FanCode2;
      3: b5 = FanCode3;
      default: b5 = 8'($urandom);
    endcase
    return cmd_frame(cmd, 8'($urandom), b3, b4, b5, b7);
  endfunction

  function automatic stim_row_t make_row(input row_kind_t kind, input logic [IntervalW-1:0] iv,
                                         input frame_bytes_t fb, input logic typed,
                                         input report_t want);
    stim_row_t r;
    r.kind     = kind;
    r.interval = iv;
    r.bytes    = fb;
    r.typed    = typed;
    r.want     = want;
    return r;
  endfunction

  task automatic send_item(input logic [IntervalW-1:0] iv, input logic typed,
                           input report_t want);
    report_t     pred;
    int unsigned gap;
    pred = decode_interval(iv);
    due_reports.push_back(typed ? want : pred);
    sent_cnt++;
    gap = no_gaps ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    pulse_interval <= iv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_frame(input frame_bytes_t fb, input logic typed, input report_t want,
                            input int break_at);
    logic b;
    for (int k = 0; k < FrameBits; k++) begin
      if (k == break_at) send_item(out_interval(), 1'b0, ReportIdle);
      b = (k < 8 * NumBytes) ? fb[k / 8][7 - k % 8] : 1'($urandom);
      send_item(bit_interval(b), typed && (k == FrameBits - 1), want);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [IntervalW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CfgBitLowLimit:  lim_low  = val;
      CfgBitHighLimit: lim_high = val;
      default:         thr_one  = val;
    endcase
  endtask

  task automatic set_limits(input logic [IntervalW-1:0] lo, hi, thr);
    drain();
    write_reg(CfgBitLowLimit, lo);
    write_reg(CfgBitHighLimit, hi);
    write_reg(CfgOneThreshold, thr);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input int unsigned budget);
    int unsigned stop_at;
    stop_at = sent_cnt + budget;
    while (sent_cnt < stop_at) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      if ((stop_at - sent_cnt >= FrameBits) && ($urandom_range(0, 9) < 8)) begin
        send_frame(random_frame(), 1'b0, ReportIdle,
                   ($urandom_range(0, 5) == 0) ? int'($urandom_range(0, FrameBits - 1)) : -1);
      end else begin
        repeat ($urandom_range(1, 8)) begin
          send_item($urandom_range(0, 1) ? 16'($urandom) : out_interval(), 1'b0, ReportIdle);
        end
      end
    end
    no_gaps = 1'b0;
  endtask

  task automatic check_field(input string name, input logic [4:0] want, input logic [4:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      mismatch_cnt++;
    end
  endtask

  task automatic check_report(input report_t want, input report_t got);
    check_field("power_on", 5'(want.st.power), 5'(got.st.power));
    check_field("set_temperature", want.st.temp, got.st.temp);
    check_field("reserve_time_value", want.st.resv_time, got.st.resv_time);
    check_field("reserve_temperature", want.st.resv_temp, got.st.resv_temp);
    check_field("op_mode", 5'(want.st.mode), 5'(got.st.mode));
    check_field("fan_speed", 5'(want.st.speed), 5'(got.st.speed));
    check_field("reserve_enabled", 5'(want.st.resv_on), 5'(got.st.resv_on));
    check_field("reserve_field_select", 5'(want.st.resv_sel), 5'(got.st.resv_sel));
    check_field("frame_done", 5'(want.done), 5'(got.done));
    check_field("frame_error", 5'(want.err), 5'(got.err));
  endtask

  always @(posedge clk) begin
    report_t got;
    got = {power_on, set_temperature, reserve_time_value, reserve_temperature, op_mode,
           fan_speed, reserve_enabled, reserve_field_select, frame_done, frame_error};
    if (rst_n && out_valid && out_ready) begin
      if (due_reports.size() == 0) begin
        $display("%0t: result with no request pending", $time);
        mismatch_cnt++;
      end else begin
        check_report(due_reports.pop_front(), got);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned hold;
    forever begin
      if ($urandom_range(0, 19) == 0) begin
        out_ready <= 1'b1;
        hold = $urandom_range(50, 200);
      end else begin
        hold = pick_gap();
        out_ready <= (hold == 0);
        if (hold == 0) hold = $urandom_range(1, 6);
      end
      repeat (hold) @(posedge clk);
    end
  end

  initial begin
    logic [IntervalW-1:0] lo_r;
    logic [IntervalW-1:0] hi_r;
    lim_low     = BitLowLimitRst;
    lim_high    = BitHighLimitRst;
    thr_one     = OneThresholdRst;
    bit_cnt     = '0;
    frame_store = '0;
    unit_state  = SettingsRst;

    dir_rows.push_back(make_row(RowPulse, 16'd801, '0, 1'b1, ReportIdle));
    dir_rows.push_back(make_row(RowPulse, 16'd2101, '0, 1'b1, ReportIdle));
    dir_rows.push_back(make_row(RowPulse, 16'd800, '0, 1'b1, ReportIdle));
    dir_rows.push_back(make_row(RowPulse, 16'd2300, '0, 1'b1, ReportIdle));
    dir_rows.push_back(make_row(RowPulse, 16'd0, '0, 1'b1, ReportIdle));
    dir_rows.push_back(make_row(RowPulse, 16'hFFFF, '0, 1'b1, ReportIdle));
    dir_rows.push_back(make_row(RowFrame, '0,
      cmd_frame(CmdUnknown, 8'hF0, TempSetSel, Pat40, FanCode0, Pat20), 1'b1, ReportBadCmd));
    dir_rows.push_back(make_row(RowFrame, '0,
      cmd_frame(CmdTempA, 8'hF0, TempBadSel, PatNone, PatNone, PatNone), 1'b1, ReportBadCmd));
    dir_rows.push_back(make_row(RowFrame, '0,
      cmd_frame(CmdPower, 8'h00, PatNone, PatNone, PatNone, PatNone), 1'b0, ReportIdle));
    dir_rows.push_back(make_row(RowFrame, '0,
      cmd_frame(CmdTempA, 8'hF0, TempSetSel, PatNone, PatNone, PatNone), 1'b0, ReportIdle));
    dir_rows.push_back(make_row(RowFrame, '0,
      cmd_frame(CmdTempA, 8'h70, TempResvSel, PatNone, PatNone, PatNone), 1'b0, ReportIdle));
    dir_rows.push_back(make_row(RowFrame, '0,
      cmd_frame(CmdResvSelect, 8'h00, PatNone, PatNone, PatNone, PatNone), 1'b0, ReportIdle));
    dir_rows.push_back(make_row(RowFrame, '0,
      cmd_frame(CmdTempB, 8'hF0, TempResvSel, PatNone, PatNone, PatNone), 1'b0, ReportIdle));
    dir_rows.push_back(make_row(RowFrame, '0,
      cmd_frame(CmdResvToggle, 8'h00, PatNone, PatNone, PatNone, PatNone), 1'b0, ReportIdle));
    dir_rows.push_back(make_row(RowFrame, '0,
      cmd_frame(CmdMode, 8'h00, PatNone, PatC0, PatNone, Pat80), 1'b0, ReportIdle));
    dir_rows.push_back(make_row(RowFrame, '0,
      cmd_frame(CmdFan, 8'h00, PatNone, PatNone, FanCode3, PatNone), 1'b0, ReportIdle));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == RowPulse) begin
        send_item(dir_rows[i].interval, dir_rows[i].typed, dir_rows[i].want);
      end else begin
        send_frame(dir_rows[i].bytes, dir_rows[i].typed, dir_rows[i].want, -1);
      end
    end

    set_limits(BitLowLimitRst, BitHighLimitRst, OneThresholdRst);
    run_random(112);
    set_limits(16'd0, 16'hFFFF, 16'd32767);
    run_random(20);
    set_limits(16'd100, 16'd400, 16'd250);
    run_random(20);
    set_limits(16'hFFFF, 16'd0, 16'hFFFF);
    run_random(10);
    set_limits(16'd0, 16'd3, 16'd0);
    run_random(10);
    set_limits(16'd1000, 16'd60000, 16'd30000);
    run_random(20);
    repeat (2) begin
      lo_r = 16'($urandom_range(0, 20000));
      hi_r = lo_r + 16'($urandom_range(2, 30000));
      set_limits(lo_r, hi_r, 16'($urandom_range(int'(hi_r), int'(lo_r))));
      run_random(10);
    end

    drain();
    if (mismatch_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
